FILE: rtl/core/scalar_kalman_cell_update_unit_assert.svh
// ----------------------------------------------------------------------------
// Scalar Kalman cell update - assertion macros
// Shared concurrent assertion helpers, sampled on the rising clock edge and
// disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_CELL_UPDATE_UNIT_ASSERT_SVH
`define SCALAR_KALMAN_CELL_UPDATE_UNIT_ASSERT_SVH

// same-cycle implication
`define SKCU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("skcu assertion failed");

// next-cycle implication
`define SKCU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("skcu assertion failed");

`endif

FILE: rtl/core/skcu_pkg.sv
// ----------------------------------------------------------------------------
// skcu_pkg
// Types and constants of the scalar Kalman cell update unit (Q16.16 default).
// ----------------------------------------------------------------------------
package skcu_pkg;

   localparam int FRAC_BITS = 16;
   localparam int GAIN_W    = FRAC_BITS + 1;
   localparam int DEN_W     = 33;
   localparam int REM_W     = 34;
   localparam int ZQ_W      = 33 + FRAC_BITS;
   localparam int PE_W      = GAIN_W + 34;
   localparam int PV_W      = GAIN_W + 32;
   localparam int CNT_W     = $clog2(GAIN_W);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [0:0] REG_VARIANCE_FLOOR = 1'b0;

   localparam logic [GAIN_W-1:0] GAIN_ONE    = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [CNT_W-1:0]  DIV_LAST    = CNT_W'(GAIN_W - 1);
   localparam logic [31:0]       VAR_RESET   = 32'(100 * (2 ** FRAC_BITS));
   localparam logic [31:0]       FLOOR_RESET = 32'((2 ** FRAC_BITS + 5) / 10);

   localparam logic signed [ZQ_W-1:0] ZQ_MAX = ZQ_W'(33'sh0_7FFF_FFFF);
   localparam logic signed [ZQ_W-1:0] ZQ_MIN = ZQ_W'(33'sh1_8000_0000);
   localparam logic signed [PE_W-1:0] PE_MAX = PE_W'(33'sh0_7FFF_FFFF);
   localparam logic signed [PE_W-1:0] PE_MIN = PE_W'(33'sh1_8000_0000);

   typedef struct packed {
      logic signed [15:0] measurement;
      logic [31:0]        measurement_variance;
   } req_type;

   typedef struct packed {
      logic signed [31:0] elevation_estimate;
      logic [31:0]        variance_estimate;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic mul;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic force_one;
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/core/skcu_dp.sv
// ----------------------------------------------------------------------------
// skcu_dp
// Datapath: cell state, restoring gain divider, blend and variance multipliers,
// floor clamp and result word register.
// ----------------------------------------------------------------------------
module skcu_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  skcu_pkg::cmd_type    cmd,
   input  skcu_pkg::req_type    req_data,
   input  logic [31:0]          variance_floor,
   output skcu_pkg::status_type status,
   output skcu_pkg::rsp_type    rsp_data
);

   logic signed [31:0] estimate_ff, estimate_in;
   logic [31:0]        variance_ff, variance_in;
   logic signed [31:0] zq_ff, zq_in;
   logic [skcu_pkg::DEN_W-1:0]  den_ff, den_in;
   logic [skcu_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic [skcu_pkg::GAIN_W-1:0] quo_ff, quo_in;
   logic                        force_ff, force_in;
   logic signed [skcu_pkg::PE_W-1:0] prod_e_ff, prod_e_in;
   logic [skcu_pkg::PV_W-1:0]        prod_v_ff, prod_v_in;
   skcu_pkg::rsp_type rsp_ff, rsp_in;

   logic signed [skcu_pkg::ZQ_W-1:0] z_wide;
   logic signed [31:0]               zq_sat;
   logic [skcu_pkg::DEN_W-1:0]       den_load;
   logic                             ge;
   logic [skcu_pkg::REM_W-1:0]       rem_diff, rem_next;
   logic [skcu_pkg::GAIN_W-1:0]      gain;
   logic signed [skcu_pkg::GAIN_W:0] gain_s;
   logic signed [32:0]               diff;
   logic signed [skcu_pkg::PE_W-1:0] delta, sum;
   logic signed [31:0]               ne;
   logic [31:0]                      nv, nv_clamp;

   always_comb begin
      z_wide = skcu_pkg::ZQ_W'(req_data.measurement) <<< skcu_pkg::FRAC_BITS;
      if (z_wide > skcu_pkg::ZQ_MAX) begin
         zq_sat = 32'sh7FFF_FFFF;
      end else if (z_wide < skcu_pkg::ZQ_MIN) begin
         zq_sat = 32'sh8000_0000;
      end else begin
         zq_sat = z_wide[31:0];
      end
      den_load = {1'b0, variance_ff} + {1'b0, req_data.measurement_variance};

      ge       = rem_ff >= {1'b0, den_ff};
      rem_diff = rem_ff - {1'b0, den_ff};
      rem_next = ge ? rem_diff : rem_ff;

      gain      = force_ff ? skcu_pkg::GAIN_ONE : quo_ff;
      gain_s    = {1'b0, gain};
      diff      = {zq_ff[31], zq_ff} - {estimate_ff[31], estimate_ff};
      prod_e_in = gain_s * diff;
      prod_v_in = (skcu_pkg::GAIN_ONE - gain) * variance_ff;

      delta = prod_e_ff >>> skcu_pkg::FRAC_BITS;
      sum   = delta + skcu_pkg::PE_W'(estimate_ff);
      if (sum > skcu_pkg::PE_MAX) begin
         ne = 32'sh7FFF_FFFF;
      end else if (sum < skcu_pkg::PE_MIN) begin
         ne = 32'sh8000_0000;
      end else begin
         ne = sum[31:0];
      end
      nv       = prod_v_ff[skcu_pkg::FRAC_BITS +: 32];
      nv_clamp = (nv < variance_floor) ? variance_floor : nv;

      zq_in       = zq_ff;
      den_in      = den_ff;
      force_in    = force_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      estimate_in = estimate_ff;
      variance_in = variance_ff;
      rsp_in      = rsp_ff;
      if (cmd.load) begin
         zq_in    = zq_sat;
         den_in   = den_load;
         force_in = (estimate_ff == 32'sd0) || (den_load == '0);
         rem_in   = {2'b00, variance_ff};
         quo_in   = '0;
      end
      if (cmd.div_step) begin
         rem_in = {rem_next[skcu_pkg::REM_W-2:0], 1'b0};
         quo_in = {quo_ff[skcu_pkg::GAIN_W-2:0], ge};
      end
      if (cmd.commit) begin
         estimate_in                = ne;
         variance_in                = nv_clamp;
         rsp_in.elevation_estimate  = ne;
         rsp_in.variance_estimate   = nv_clamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         estimate_ff <= '0;
         variance_ff <= skcu_pkg::VAR_RESET;
      end else begin
         estimate_ff <= estimate_in;
         variance_ff <= variance_in;
      end
   end

   always_ff @(posedge clock) begin
      zq_ff    <= zq_in;
      den_ff   <= den_in;
      force_ff <= force_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      rsp_ff   <= rsp_in;
      if (cmd.mul) begin
         prod_e_ff <= prod_e_in;
         prod_v_ff <= prod_v_in;
      end
   end

   assign status.force_one = force_ff;
   assign rsp_data         = rsp_ff;

endmodule

FILE: rtl/core/skcu_ctrl.sv
// ----------------------------------------------------------------------------
// skcu_ctrl
// Sequencer: accept, gain divide steps, multiply, commit into the result word
// register; owns the handshake state of both channels.
// ----------------------------------------------------------------------------
module skcu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  skcu_pkg::status_type status,
   output skcu_pkg::cmd_type    cmd
);

   skcu_pkg::state_type state_ff, state_in;
   logic [skcu_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skcu_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         skcu_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = skcu_pkg::ST_DIV;
            end
         end
         skcu_pkg::ST_DIV: begin
            if (status.force_one) begin
               state_in = skcu_pkg::ST_MUL;
            end else begin
               cmd.div_step = 1'b1;
               if (cnt_ff == skcu_pkg::DIV_LAST) begin
                  state_in = skcu_pkg::ST_MUL;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         skcu_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = skcu_pkg::ST_DONE;
         end
         skcu_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = skcu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = skcu_pkg::ST_IDLE;
         end
      endcase
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   assign req_ready = (state_ff == skcu_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/core/scalar_kalman_cell_update_unit.sv
// ----------------------------------------------------------------------------
// scalar_kalman_cell_update_unit
// One-dimensional Kalman update of a single map cell in Q16.16.
//
//   channel  ports       direction  word
//   req      req_*       in         measurement, measurement_variance
//   rsp      rsp_*       out        elevation_estimate, variance_estimate
//   csr      csr_*       in/out     variance_floor at byte address 0
//
// An item passes from accept to result through a load step, 17 steps of
// the restoring gain divider (one quotient bit each), a multiply step and
// a commit step. A forced unity gain skips the divider.
// Reset is synchronous; state returns to estimate 0, variance 100.0.
// A stalled result waits in the output register; the next word is accepted
// meanwhile, and its commit waits until the register is free.
// ----------------------------------------------------------------------------
module scalar_kalman_cell_update_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  skcu_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output skcu_pkg::rsp_type                 rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [skcu_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [skcu_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [skcu_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

`include "scalar_kalman_cell_update_unit_assert.svh"

   logic [31:0] floor_ff, floor_in;
   logic        floor_sel;
   skcu_pkg::cmd_type    cmd;
   skcu_pkg::status_type status;

   assign floor_sel = (csr_paddr[2] == skcu_pkg::REG_VARIANCE_FLOOR);

   always_comb begin
      floor_in = floor_ff;
      if (csr_psel && csr_penable && csr_pwrite && floor_sel) begin
         floor_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= skcu_pkg::FLOOR_RESET;
      end else begin
         floor_ff <= floor_in;
      end
   end

   assign csr_prdata = floor_sel ? floor_ff : '0;
   assign csr_pready = 1'b1;

   skcu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   skcu_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_data       (req_data),
      .variance_floor (floor_ff),
      .status         (status),
      .rsp_data       (rsp_data)
   );

   `SKCU_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `SKCU_ASSERT_SAME(a_commit_slot_free, clock, reset, cmd.commit, !rsp_valid || rsp_ready)
   `SKCU_ASSERT_NEXT(a_commit_shows_word, clock, reset, cmd.commit, rsp_valid)
   `SKCU_ASSERT_SAME(a_rsp_above_floor, clock, reset, rsp_valid, rsp_data.variance_estimate >= floor_ff)

endmodule
